// File: rtl/core/tsxy_pkg.sv
package tsxy_pkg;

    localparam int INDEX_BITS = 31;
    localparam int COORD_BITS = 19;

    // one root bit is settled per pipeline stage
    localparam int ROOT_BITS = (INDEX_BITS + 1) / 2;
    localparam int PAD_BITS  = 2 * ROOT_BITS;
    localparam int REM_BITS  = ROOT_BITS + 2;
    localparam int CALC_BITS = (ROOT_BITS + 2 > COORD_BITS) ? ROOT_BITS + 2 : COORD_BITS;

    localparam int IN_DATA_BITS  = ((INDEX_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic [PAD_BITS-1:0]  rest;
        logic [REM_BITS-1:0]  rem;
        logic [ROOT_BITS-1:0] root;
    } t_root_word;

endpackage

// File: rtl/core/triangular_spiral_index_to_xy_core.sv
// Maps a triangular spiral point index to its (x, y) coordinates. One index
// can be accepted every clock cycle while no output word is stalled; each
// result passes through one stage per square root bit in the restoring root
// pipeline, then one stage that rounds to the nearest root and one that forms
// the coordinates. The whole pipeline advances together and holds in place
// while an output word waits for i_m_axis_tready.
module triangular_spiral_index_to_xy_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // [30:0] point_index
    input  logic [tsxy_pkg::IN_DATA_BITS-1:0]     i_s_axis_tdata,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // [18:0] coord_x, [37:19] coord_y
    output logic [tsxy_pkg::OUT_DATA_BITS-1:0]    o_m_axis_tdata
);

    logic                                  en;
    logic [tsxy_pkg::ROOT_BITS:0]          valid;
    tsxy_pkg::t_root_word                  word [tsxy_pkg::ROOT_BITS+1];
    logic                                  out_valid;
    logic signed [tsxy_pkg::COORD_BITS-1:0] coord_x;
    logic signed [tsxy_pkg::COORD_BITS-1:0] coord_y;

    assign en = !out_valid || i_m_axis_tready;

    assign valid[0]     = i_s_axis_tvalid;
    assign word[0].rest = tsxy_pkg::PAD_BITS'(i_s_axis_tdata[tsxy_pkg::INDEX_BITS-1:0]);
    assign word[0].rem  = '0;
    assign word[0].root = '0;

    for (genvar g = 0; g < tsxy_pkg::ROOT_BITS; g++) begin : g_root
        tsxy_root_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (valid[g]),
            .i_word  (word[g]),
            .o_valid (valid[g+1]),
            .o_word  (word[g+1])
        );
    end

    tsxy_coord u_coord (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (valid[tsxy_pkg::ROOT_BITS]),
        .i_word    (word[tsxy_pkg::ROOT_BITS]),
        .o_valid   (out_valid),
        .o_coord_x (coord_x),
        .o_coord_y (coord_y)
    );

    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = out_valid;
    assign o_m_axis_tdata  = tsxy_pkg::OUT_DATA_BITS'({coord_y, coord_x});

endmodule

// File: rtl/core/tsxy_root_stage.sv
module tsxy_root_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  tsxy_pkg::t_root_word i_word,
    output logic                o_valid,
    output tsxy_pkg::t_root_word o_word
);

    logic [tsxy_pkg::REM_BITS-1:0] shifted;
    logic [tsxy_pkg::REM_BITS-1:0] trial;
    logic                          ge;
    tsxy_pkg::t_root_word          n_word;
    logic                          r_valid;
    tsxy_pkg::t_root_word          r_word;

    // bring down the next two index bits and try the next root bit
    always_comb begin
        shifted = {i_word.rem[tsxy_pkg::REM_BITS-3:0],
                   i_word.rest[tsxy_pkg::PAD_BITS-1 -: 2]};
        trial   = {i_word.root, 2'b01};
        ge      = (shifted >= trial);
        n_word.rest = {i_word.rest[tsxy_pkg::PAD_BITS-3:0], 2'b00};
        n_word.rem  = ge ? (shifted - trial) : shifted;
        n_word.root = {i_word.root[tsxy_pkg::ROOT_BITS-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// File: rtl/core/tsxy_coord.sv
module tsxy_coord (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  tsxy_pkg::t_root_word                i_word,
    output logic                                o_valid,
    output logic signed [tsxy_pkg::COORD_BITS-1:0] o_coord_x,
    output logic signed [tsxy_pkg::COORD_BITS-1:0] o_coord_y
);

    logic                              up;
    logic [tsxy_pkg::ROOT_BITS:0]      n_r;
    logic [tsxy_pkg::ROOT_BITS-1:0]    n_ad;
    logic [tsxy_pkg::REM_BITS-1:0]     back;
    logic                              r_a_valid;
    logic [tsxy_pkg::ROOT_BITS:0]      r_r;
    logic [tsxy_pkg::ROOT_BITS-1:0]    r_ad;
    logic                              r_neg;
    logic                              r_pos;

    logic                              odd;
    logic                              add_y;
    logic [tsxy_pkg::CALC_BITS-1:0]    rx;
    logic [tsxy_pkg::CALC_BITS-1:0]    ax;
    logic [tsxy_pkg::CALC_BITS-1:0]    half;
    logic [tsxy_pkg::CALC_BITS-1:0]    n_x;
    logic [tsxy_pkg::CALC_BITS-1:0]    n_y;
    logic                              r_b_valid;
    logic [tsxy_pkg::COORD_BITS-1:0]   r_x;
    logic [tsxy_pkg::COORD_BITS-1:0]   r_y;

    // nearest root: round up when the remainder passes the floor root
    // then |n - r*r| is the remainder or 2f+1 minus it
    always_comb begin
        up   = i_word.rem > tsxy_pkg::REM_BITS'(i_word.root);
        back = tsxy_pkg::REM_BITS'({i_word.root, 1'b1}) - i_word.rem;
        n_r  = {1'b0, i_word.root} + (tsxy_pkg::ROOT_BITS+1)'(up);
        n_ad = up ? back[tsxy_pkg::ROOT_BITS-1:0]
                  : i_word.rem[tsxy_pkg::ROOT_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r   <= n_r;
            r_ad  <= n_ad;
            r_neg <= up;
            r_pos <= !up && (i_word.rem != '0);
        end
    end

    // odd r: square at (r, -(r>>1)); even r: square at (-r, -(r>>1))
    always_comb begin
        odd   = r_r[0];
        rx    = tsxy_pkg::CALC_BITS'(r_r);
        ax    = tsxy_pkg::CALC_BITS'(r_ad);
        half  = tsxy_pkg::CALC_BITS'(r_r[tsxy_pkg::ROOT_BITS:1]);
        add_y = (odd && r_pos) || (!odd && r_neg);
        n_x   = odd ? (rx - ax) : (ax - rx);
        n_y   = (add_y ? ax : '0) - half;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x[tsxy_pkg::COORD_BITS-1:0];
            r_y <= n_y[tsxy_pkg::COORD_BITS-1:0];
        end
    end

    assign o_valid   = r_b_valid;
    assign o_coord_x = r_x;
    assign o_coord_y = r_y;

endmodule

// File: bench/spiral_xy_checker.sv
module spiral_xy_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    input  logic                                i_s_tready,
    // [30:0] point_index
    input  logic [tsxy_pkg::IN_DATA_BITS-1:0]   i_s_tdata,
    input  logic                                i_m_tvalid,
    input  logic                                i_m_tready,
    // [18:0] coord_x, [37:19] coord_y
    input  logic [tsxy_pkg::OUT_DATA_BITS-1:0]  i_m_tdata,
    output int                                  o_fail_count,
    output int                                  o_pending
);

    typedef struct packed {
        logic signed [tsxy_pkg::COORD_BITS-1:0] y;
        logic signed [tsxy_pkg::COORD_BITS-1:0] x;
    } spiral_xy_t;

    spiral_xy_t expected_xy[$];

    // nearest integer root, then walk from the square point along one edge
    function automatic spiral_xy_t xy_of_index(input logic [tsxy_pkg::INDEX_BITS-1:0] idx);
        longint unsigned n;
        longint unsigned root;
        longint unsigned probe;
        longint unsigned r;
        longint          d;
        longint          k;
        longint          x;
        longint          y;
        spiral_xy_t      xy;
        n    = 64'(idx);
        root = 0;
        for (int b = tsxy_pkg::ROOT_BITS - 1; b >= 0; b--) begin
            probe = root | (64'd1 << b);
            if (probe * probe <= n) begin
                root = probe;
            end
        end
        r = (n - root * root > root) ? root + 1 : root;
        d = longint'(n) - longint'(r * r);
        if (r[0]) begin
            k = longint'((r - 1) >> 1);
            x = 1 + 2 * k;
            y = -k;
            if (d > 0) begin
                x = x - d;
                y = y + d;
            end else if (d < 0) begin
                x = x + d;
            end
        end else begin
            k = longint'(r >> 1);
            x = -2 * k;
            y = -k;
            if (d > 0) begin
                x = x + d;
            end else if (d < 0) begin
                x = x - d;
                y = y - d;
            end
        end
        xy.x = x[tsxy_pkg::COORD_BITS-1:0];
        xy.y = y[tsxy_pkg::COORD_BITS-1:0];
        return xy;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        spiral_xy_t want;
        spiral_xy_t got;
        if (i_rst_n) begin
            // check the output word before queueing the new index
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[2*tsxy_pkg::COORD_BITS-1:0];
                if (expected_xy.size() == 0) begin
                    $display("%0t: unexpected word x=%0d y=%0d", $time, got.x, got.y);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_xy.pop_front();
                    if (got.x !== want.x || got.y !== want.y) begin
                        $display("%0t: mismatch expected x=%0d y=%0d actual x=%0d y=%0d",
                                 $time, want.x, want.y, got.x, got.y);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_xy.push_back(xy_of_index(i_s_tdata[tsxy_pkg::INDEX_BITS-1:0]));
            end
            o_pending <= expected_xy.size();
        end
    end

endmodule

// File: bench/triangular_spiral_index_to_xy_core_tb.sv
module triangular_spiral_index_to_xy_core_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_WORDS = 560;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 30;
    localparam longint MAX_INDEX = (64'd1 << tsxy_pkg::INDEX_BITS) - 1;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                s_tvalid;
    logic                                s_tready;
    logic [tsxy_pkg::IN_DATA_BITS-1:0]   s_tdata;
    logic                                m_tvalid;
    logic                                m_tready;
    logic [tsxy_pkg::OUT_DATA_BITS-1:0]  m_tdata;
    int                                  fail_count;
    int                                  pending;

    int send_idle_pct;
    int recv_idle_pct;
    int hold_requests;

    triangular_spiral_index_to_xy_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    spiral_xy_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("tb: failure");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off whenever one is requested
    initial begin
        int hold_left;
        int holds_seen;
        hold_left  = 0;
        holds_seen = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holds_seen != hold_requests) begin
                holds_seen = hold_requests;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // four in ten indices lie near perfect squares, where the root rounding flips
    function automatic logic [tsxy_pkg::INDEX_BITS-1:0] pick_index();
        int unsigned sel;
        longint      s;
        longint      v;
        sel = $urandom_range(9);
        if (sel < 4) begin
            v = longint'($urandom) & MAX_INDEX;
        end else if (sel < 6) begin
            v = longint'($urandom_range(2000));
        end else begin
            s = longint'($urandom_range(46340));
            v = s * s + longint'($urandom_range(32'(2 * s + 2))) - (s + 1);
            if (v < 0) begin
                v = 0;
            end
            if (v > MAX_INDEX) begin
                v = MAX_INDEX;
            end
        end
        return v[tsxy_pkg::INDEX_BITS-1:0];
    endfunction

    task automatic send_index(input logic [tsxy_pkg::INDEX_BITS-1:0] idx);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= tsxy_pkg::IN_DATA_BITS'(idx);
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic wait_all_words();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        logic [tsxy_pkg::INDEX_BITS-1:0] corner_idx[$];
        corner_idx = '{0, 1, 2, 3, 4, 5, 6, 8, 9, 15, 16, 24, 25,
                       31'd1073741824, 31'h5555_5555, 31'h2AAA_AAAA,
                       31'd2147395600, 31'd2147395599, 31'd2147441940,
                       31'd2147441941, 31'h7FFF_FFFE, 31'h7FFF_FFFF};
        s_tvalid      <= 1'b0;
        s_tdata       <= '0;
        i_rst_n       <= 1'b0;
        send_idle_pct = 24;
        recv_idle_pct = 57;
        hold_requests = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (corner_idx[j]) begin
            send_index(corner_idx[j]);
        end

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 24 : (ph == 1) ? 57 : 0;
            recv_idle_pct = (ph == 0) ? 57 : (ph == 1) ? 24 : 0;
            for (int i = 0; i < PHASE_WORDS; i++) begin
                // long receiver hold-off while indices keep coming
                if (ph == 2 && i == 100) begin
                    hold_requests++;
                end
                if (ph == 2 && i == 200) begin
                    wait_all_words();
                end
                send_index(pick_index());
            end
            wait_all_words();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
